// File: rtl/pure_pursuit_steering_unit_macros.svh
// Assertion macros for the top-level RTL file
`ifndef PURE_PURSUIT_STEERING_UNIT_MACROS_SVH
`define PURE_PURSUIT_STEERING_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PPSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ppsu_pkg.sv
`default_nettype none
package ppsu_pkg;

	// path store
	localparam int PPSU_PATH_DEPTH = 1024;

	// field widths
	localparam int POS_W   = 20;
	localparam int HD_W    = 16;
	localparam int STEER_W = 15;
	localparam int SPD_W   = 12;
	localparam int GOAL_W  = 10;

	// configuration register widths
	localparam int WB_W    = 12;
	localparam int LA_W    = 14;
	localparam int RATIO_W = 16;
	localparam int MAXS_W  = 14;
	localparam int WIN_W   = 10;

	// APB
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam logic [2:0] REG_WHEELBASE = 3'd0;
	localparam logic [2:0] REG_LOOKAHEAD = 3'd1;
	localparam logic [2:0] REG_SET_SPEED = 3'd2;
	localparam logic [2:0] REG_MIN_RATIO = 3'd3;
	localparam logic [2:0] REG_MAX_STEER = 3'd4;
	localparam logic [2:0] REG_WINDOW    = 3'd5;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = 4;
	localparam int XW           = 60;
	localparam int ZW           = 26;
	localparam int KINV_Q16     = 39797;

	// speed divider
	localparam int DIV_NW = 31;
	localparam int SPEED_FLOOR = 26;

	typedef struct packed {
		logic start;
		logic vec;	// 1: vectoring (drive y to zero), 0: rotation
	} cordic_ctl_t;

	// arctan(2^-i), 2^24 per turn
	function automatic logic signed [ZW-1:0] cordic_atan(input logic [STEP_W-1:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			4'd0:    a = 26'sd2097152;
			4'd1:    a = 26'sd1238021;
			4'd2:    a = 26'sd654136;
			4'd3:    a = 26'sd332050;
			4'd4:    a = 26'sd166669;
			4'd5:    a = 26'sd83416;
			4'd6:    a = 26'sd41718;
			4'd7:    a = 26'sd20860;
			4'd8:    a = 26'sd10430;
			4'd9:    a = 26'sd5215;
			4'd10:   a = 26'sd2608;
			4'd11:   a = 26'sd1304;
			4'd12:   a = 26'sd652;
			4'd13:   a = 26'sd326;
			4'd14:   a = 26'sd163;
			4'd15:   a = 26'sd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// File: rtl/ppsu_in_if.sv
`default_nettype none
interface ppsu_in_if import ppsu_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic                    first_point;
	logic signed [POS_W-1:0] x_position;
	logic signed [POS_W-1:0] y_position;
	logic signed [HD_W-1:0]  heading;

	modport source (output valid, kind, first_point, x_position, y_position, heading,
		input ready);
	modport sink (input valid, kind, first_point, x_position, y_position, heading,
		output ready);
endinterface
`default_nettype wire

// File: rtl/ppsu_out_if.sv
`default_nettype none
interface ppsu_out_if import ppsu_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [STEER_W-1:0] steer_angle;
	logic [SPD_W-1:0]          drive_speed;
	logic [GOAL_W-1:0]         goal_index;

	modport source (output valid, steer_angle, drive_speed, goal_index, input ready);
	modport sink (input valid, steer_angle, drive_speed, goal_index, output ready);
endinterface
`default_nettype wire

// File: rtl/ppsu_ram.sv
`default_nettype none
module ppsu_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/ppsu_cordic.sv
`default_nettype none
module ppsu_cordic import ppsu_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cordic_ctl_t          ctl,
	input  wire logic signed [XW-1:0] x0,
	input  wire logic signed [XW-1:0] y0,
	input  wire logic signed [ZW-1:0] z0,
	output logic                      done,
	output logic signed [XW-1:0]      x,
	output logic signed [XW-1:0]      y,
	output logic signed [ZW-1:0]      z
);
	logic signed [XW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, a;
	logic [STEP_W-1:0]    step_q;
	logic                 run_q, done_q, vec_q, sigma;

	// one micro-rotation per cycle
	always_comb begin
		xs    = x_q >>> step_q;
		ys    = y_q >>> step_q;
		a     = cordic_atan(step_q);
		sigma = vec_q ? y_q[XW-1] : !z_q[ZW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			vec_q <= ctl.vec;
		end else if (run_q) begin
			if (sigma) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
endmodule
`default_nettype wire

// File: rtl/ppsu_div.sv
`default_nettype none
module ppsu_div import ppsu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] dividend,
	input  wire logic [MAXS_W-1:0] divisor,
	output logic                   done,
	output logic [DIV_NW-1:0]      quotient
);
	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [MAXS_W-1:0] rem_q, div_q;
	logic [DIV_NW-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q, done_q, ge;
	logic [MAXS_W:0]   trial, diff;

	// restoring step: one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[DIV_NW-1]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[MAXS_W-1:0] : trial[MAXS_W-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// File: rtl/pure_pursuit_steering_unit.sv
// channel | dir | payload                                           | transfer
// item    | in  | kind, first_point, x_position, y_position, heading | valid && ready
// result  | out | steer_angle, drive_speed, goal_index               | valid && ready
// apb     | in  | register writes and reads                          | psel && penable
//
// A path point is written to the point memory on transfer, unless the path is full and it is not a first point.
// A pose steps through memory read, squares and compare for each searched point,
// then the goal read, two 16-step CORDIC passes and the
// 31-step speed divider (skipped when max_steer is zero);
// the single-port read of the point memory paces the search.
// Reset clears the path count and search start; the point memory is not cleared.
// The result sits in an output register, so item is taken again while it waits.
`default_nettype none
module pure_pursuit_steering_unit import ppsu_pkg::*; #(
	parameter int PATH_DEPTH = PPSU_PATH_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ppsu_in_if.sink                item,
	ppsu_out_if.source             result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);
	localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
	localparam int CW = $clog2(PATH_DEPTH + 1);
	localparam int SW = ((AW > WIN_W) ? AW : WIN_W) + ((CW > AW) ? CW - AW : 0) + 2;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RD    = 5'd1;
	localparam logic [4:0] S_SQ    = 5'd2;
	localparam logic [4:0] S_CMP   = 5'd3;
	localparam logic [4:0] S_GRD   = 5'd4;
	localparam logic [4:0] S_ROT   = 5'd5;
	localparam logic [4:0] S_RWAIT = 5'd6;
	localparam logic [4:0] S_NUM   = 5'd7;
	localparam logic [4:0] S_VST   = 5'd8;
	localparam logic [4:0] S_VWAIT = 5'd9;
	localparam logic [4:0] S_PROD  = 5'd10;
	localparam logic [4:0] S_DST   = 5'd11;
	localparam logic [4:0] S_DWAIT = 5'd12;
	localparam logic [4:0] S_SPD   = 5'd13;
	localparam logic [4:0] S_OUT   = 5'd14;

	// configuration registers
	logic [WB_W-1:0]    wb_q;
	logic [LA_W-1:0]    la_q;
	logic [SPD_W-1:0]   spd_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [MAXS_W-1:0]  maxs_q;
	logic [WIN_W-1:0]   win_q;

	logic [4:0]                state_q;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             start_q, idx_q, end_q, goal_q, last;
	logic signed [POS_W-1:0]   px_q, py_q;
	logic [HD_W-1:0]           hd_q;
	logic [2*LA_W-1:0]         ld2_q;
	logic [43:0]               sqx_q, sqy_q;
	logic signed [41:0]        ymul_q;
	logic signed [39:0]        num_q;
	logic signed [STEER_W-1:0] steer_q;
	logic [DIV_NW-1:0]         prod_q;
	logic [RATIO_W:0]          red_q;
	logic                      out_valid_q;
	logic signed [STEER_W-1:0] out_steer_q;
	logic [SPD_W-1:0]          out_spd_q;
	logic [GOAL_W-1:0]         out_goal_q;

	logic                   in_xfer, out_free, pt_wr, store_ok;
	logic [AW-1:0]          raddr, waddr;
	logic [2*POS_W-1:0]     rdata;
	logic signed [POS_W-1:0] rx, ry;
	logic signed [21:0]     ex, ey, dxn, dyn;
	logic [SW-1:0]          win_end;
	logic [44:0]            sqsum;
	logic [HD_W-1:0]        t16;
	logic signed [16:0]     th;
	logic                   flip;
	logic signed [25:0]     yr;
	logic signed [17:0]     st_full;
	logic [MAXS_W-1:0]      mag;
	logic [29:0]            vsum;
	logic [SPD_W:0]         vraw;
	logic [RATIO_W:0]       red_n;

	cordic_ctl_t          cctl;
	logic signed [XW-1:0] cx0, cy0, cx, cy;
	logic signed [ZW-1:0] cz0, cz;
	logic                 cdone, dstart, ddone;
	logic [DIV_NW-1:0]    quo;

	assign in_xfer    = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign out_free   = !out_valid_q || result.ready;
	assign store_ok   = item.first_point || (count_q < CW'(PATH_DEPTH));
	assign pt_wr      = in_xfer && item.kind && store_ok;
	assign waddr      = item.first_point ? '0 : count_q[AW-1:0];
	assign raddr      = (state_q == S_GRD) ? goal_q : idx_q;
	assign last       = AW'(count_q - 1'b1);
	assign rx         = rdata[2*POS_W-1:POS_W];
	assign ry         = rdata[POS_W-1:0];

	ppsu_ram #(.WIDTH(2 * POS_W), .DEPTH(PATH_DEPTH)) u_path (
		.clk   (clk),
		.we    (pt_wr),
		.waddr (waddr),
		.wdata ({item.x_position, item.y_position}),
		.raddr (raddr),
		.rdata (rdata)
	);

	ppsu_cordic u_cordic (
		.clk (clk), .arst_n (arst_n), .ctl (cctl),
		.x0 (cx0), .y0 (cy0), .z0 (cz0),
		.done (cdone), .x (cx), .y (cy), .z (cz)
	);

	ppsu_div u_div (
		.clk (clk), .arst_n (arst_n), .start (dstart),
		.dividend (prod_q), .divisor (maxs_q),
		.done (ddone), .quotient (quo)
	);

	// search window end and offsets to the point just read
	always_comb begin
		win_end = SW'(start_q) + SW'(win_q);
		ex      = 22'(rx) - 22'(px_q);
		ey      = 22'(ry) - 22'(py_q);
		sqsum   = 45'(sqx_q) + 45'(sqy_q);
	end

	// rotation angle: -(yaw + quarter turn), folded into +-quarter turn
	always_comb begin
		t16  = 16'h0 - hd_q - 16'h4000;
		th   = 17'(signed'(t16));
		flip = 1'b0;
		if (th > 17'sd16384) begin
			flip = 1'b1;
			th   = th - 17'sd32768;
		end else if (th < -17'sd16384) begin
			flip = 1'b1;
			th   = th + 17'sd32768;
		end
		dxn = flip ? -ex : ex;
		dyn = flip ? -ey : ey;
	end

	// CORDIC operands
	always_comb begin
		cctl.start = (state_q == S_ROT) || (state_q == S_VST);
		cctl.vec   = (state_q == S_VST);
		if (state_q == S_VST) begin
			cx0 = XW'({ld2_q, 20'd0});
			cy0 = XW'({num_q, 20'd0});
			cz0 = '0;
		end else begin
			cx0 = XW'(dxn);
			cy0 = XW'(dyn);
			cz0 = ZW'(signed'({th, 8'd0}));
		end
	end

	// steer angle, speed terms
	always_comb begin
		yr      = 26'((ymul_q + 42'sd32768) >>> 16);
		st_full = 18'((cz + 26'sd128) >>> 8);
		mag     = steer_q[STEER_W-1] ? MAXS_W'(-steer_q) : MAXS_W'(steer_q);
		dstart  = (state_q == S_DST) && (maxs_q != '0);
		red_n   = (quo > DIV_NW'(17'h10000)) ? 17'h10000 : quo[RATIO_W:0];
		vsum    = 30'(spd_q) * 30'(17'h10000 - red_q) + 30'd32768;
		vraw    = vsum[28:16];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && item.kind) begin
						if (item.first_point) begin
							count_q <= CW'(1);
							start_q <= '0;
						end else if (store_ok) begin
							count_q <= count_q + 1'b1;
						end
					end else if (in_xfer && (count_q != '0)) begin
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_SQ;
				S_SQ:  state_q <= S_CMP;
				S_CMP: begin
					if (sqsum >= 45'(ld2_q) || idx_q == end_q) begin
						state_q <= S_GRD;
					end else begin
						state_q <= S_RD;
					end
				end
				S_GRD:   state_q <= S_ROT;
				S_ROT:   state_q <= S_RWAIT;
				S_RWAIT: if (cdone) state_q <= S_NUM;
				S_NUM:   state_q <= S_VST;
				S_VST:   state_q <= S_VWAIT;
				S_VWAIT: if (cdone) state_q <= S_PROD;
				S_PROD:  state_q <= S_DST;
				S_DST:   state_q <= (maxs_q != '0) ? S_DWAIT : S_SPD;
				S_DWAIT: if (ddone) state_q <= S_SPD;
				S_SPD:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						start_q     <= goal_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q  <= item.x_position;
				py_q  <= item.y_position;
				hd_q  <= item.heading;
				idx_q <= start_q;
				end_q <= (win_end > SW'(last)) ? last : AW'(win_end);
				ld2_q <= (2*LA_W)'(la_q) * (2*LA_W)'(la_q);
			end
			S_SQ: begin
				sqx_q <= 44'(44'(ex) * 44'(ex));
				sqy_q <= 44'(44'(ey) * 44'(ey));
			end
			S_CMP: begin
				if (sqsum >= 45'(ld2_q)) begin
					goal_q <= idx_q;
				end else if (idx_q == end_q) begin
					goal_q <= last;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_RWAIT: ymul_q <= 42'(cy) * 42'sd39797;
			S_NUM:   num_q  <= 40'(yr) * 40'(signed'({1'b0, wb_q, 1'b0}));
			S_VWAIT: begin
				if (st_full > 18'(signed'({1'b0, maxs_q}))) begin
					steer_q <= STEER_W'(signed'({1'b0, maxs_q}));
				end else if (st_full < -18'(signed'({1'b0, maxs_q}))) begin
					steer_q <= -STEER_W'(signed'({1'b0, maxs_q}));
				end else begin
					steer_q <= STEER_W'(st_full);
				end
			end
			S_PROD: prod_q <= DIV_NW'(mag) * DIV_NW'(17'h10000 - {1'b0, ratio_q});
			S_DST:  red_q  <= '0;
			S_DWAIT: if (ddone) red_q <= red_n;
			S_OUT: begin
				if (out_free) begin
					out_steer_q <= steer_q;
					out_spd_q   <= (vraw < (SPD_W+1)'(SPEED_FLOOR)) ?
						SPD_W'(SPEED_FLOOR) : vraw[SPD_W-1:0];
					out_goal_q  <= GOAL_W'(goal_q);
				end
			end
			default: ;
		endcase
	end

	assign result.valid       = out_valid_q;
	assign result.steer_angle = out_steer_q;
	assign result.drive_speed = out_spd_q;
	assign result.goal_index  = out_goal_q;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q    <= WB_W'(274);
			la_q    <= LA_W'(819);
			spd_q   <= SPD_W'(256);
			ratio_q <= RATIO_W'(13107);
			maxs_q  <= MAXS_W'(4360);
			win_q   <= WIN_W'(30);
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_WHEELBASE: wb_q    <= pwdata[WB_W-1:0];
				REG_LOOKAHEAD: la_q    <= pwdata[LA_W-1:0];
				REG_SET_SPEED: spd_q   <= pwdata[SPD_W-1:0];
				REG_MIN_RATIO: ratio_q <= pwdata[RATIO_W-1:0];
				REG_MAX_STEER: maxs_q  <= pwdata[MAXS_W-1:0];
				REG_WINDOW:    win_q   <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_WHEELBASE: prdata = APB_DW'(wb_q);
			REG_LOOKAHEAD: prdata = APB_DW'(la_q);
			REG_SET_SPEED: prdata = APB_DW'(spd_q);
			REG_MIN_RATIO: prdata = APB_DW'(ratio_q);
			REG_MAX_STEER: prdata = APB_DW'(maxs_q);
			REG_WINDOW:    prdata = APB_DW'(win_q);
			default:       prdata = '0;
		endcase
	end

	`include "pure_pursuit_steering_unit_macros.svh"

	`PPSU_ASSERT_NOW(a_busy_has_path, state_q != S_IDLE, count_q != '0, "busy without a path")
	`PPSU_ASSERT_NOW(a_start_in_path, count_q != '0, CW'(start_q) < count_q, "start beyond path")
	`PPSU_ASSERT_NOW(a_idx_in_window, state_q == S_CMP, idx_q <= end_q, "search past window end")
	`PPSU_ASSERT_NEXT(a_pose_no_path, in_xfer && !item.kind && count_q == '0,
		state_q == S_IDLE, "pose without path left idle")

endmodule
`default_nettype wire
